/* rtl/psu_pkg.sv */
package psu_pkg;

  // Field and register widths
  localparam int DATA_W     = 8;
  localparam int BPP_W      = 4;
  localparam int LINE_W     = 14;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 14;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BPP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE = 1'b1;

  // Register reset values
  localparam logic [BPP_W-1:0]  BPP_RESET  = 4'd1;
  localparam logic [LINE_W-1:0] LINE_RESET = 14'd8192;

  // Highest legal filter type code
  localparam logic [DATA_W-1:0] FLT_LAST_CODE = 8'd4;

  typedef enum logic [2:0] {
    FLT_NONE  = 3'd0,
    FLT_SUB   = 3'd1,
    FLT_UP    = 3'd2,
    FLT_AVG   = 3'd3,
    FLT_PAETH = 3'd4
  } filter_t;

  // Decoded item handed from the control stage to reconstruction
  typedef struct packed {
    logic              err;
    logic [DATA_W-1:0] x;
    filter_t           filter;
    logic              last;
    logic              a_ok;
    logic              c_ok;
    logic              first;
  } stage_t;

endpackage

/* rtl/psu_if.sv */
interface psu_in_if;
  logic                      valid;
  logic                      ready;
  logic [psu_pkg::DATA_W-1:0] data_byte;
  logic                      image_start;

  modport source (output valid, output data_byte, output image_start, input ready);
  modport sink   (input valid, input data_byte, input image_start, output ready);
endinterface

interface psu_out_if;
  logic                      valid;
  logic                      ready;
  logic [psu_pkg::DATA_W-1:0] pixel_byte;
  logic                      line_last;
  logic                      bad_filter;

  modport source (output valid, output pixel_byte, output line_last, output bad_filter,
                  input ready);
  modport sink   (input valid, input pixel_byte, input line_last, input bad_filter,
                  output ready);
endinterface

/* rtl/psu_ctrl.sv */
module psu_ctrl #(
  parameter int MAX_LINE_BYTES  = 8192,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  psu_in_if.sink                             in_ch,
  input  logic                               cfg_we,
  input  logic [psu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               adv,
  output logic                               stg_v_r,
  output psu_pkg::stage_t                    stg_r,
  output logic [((MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1)-1:0] slot_r,
  output logic [$clog2(MAX_LINE_BYTES)-1:0]  spos_r,
  output logic                               rd_en,
  output logic [$clog2(MAX_LINE_BYTES)-1:0]  rd_addr
);

  localparam int PW = $clog2(MAX_LINE_BYTES);
  localparam int SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int LW = $clog2(MAX_LINE_BYTES + 1);
  localparam int CW = (LW > psu_pkg::LINE_W) ? LW : psu_pkg::LINE_W;
  localparam int BW = psu_pkg::BPP_W;

  logic [BW-1:0]             bpp_r;
  logic [psu_pkg::LINE_W-1:0] len_r;
  logic                      awaiting_r, awaiting_nxt;
  logic                      first_r, first_nxt;
  logic                      halted_r, halted_nxt;
  logic [PW-1:0]             pos_r, pos_nxt;
  psu_pkg::filter_t          filter_r, filter_nxt;
  logic [SW-1:0]             cnt_r   [MAX_PIXEL_BYTES];
  logic [SW-1:0]             cnt_nxt [MAX_PIXEL_BYTES];

  logic [BW-1:0] bpp_eff;
  logic [CW-1:0] len_eff;
  logic [CW-1:0] len_ext;
  logic [CW-1:0] pos_inc;
  logic [SW-1:0] bpp_idx;
  logic          acc, await_type, first_line, bad, last, a_ok, emit;
  logic [PW-1:0] cur_pos;

  // Clamp the registers into their working ranges
  always_comb begin
    if (bpp_r == '0) begin
      bpp_eff = BW'(1);
    end else if (bpp_r > BW'(MAX_PIXEL_BYTES)) begin
      bpp_eff = BW'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = bpp_r;
    end
    len_ext = CW'(len_r);
    if (len_ext == '0) begin
      len_eff = CW'(1);
    end else if (len_ext > CW'(MAX_LINE_BYTES)) begin
      len_eff = CW'(MAX_LINE_BYTES);
    end else begin
      len_eff = len_ext;
    end
  end

  assign in_ch.ready = !stg_v_r || adv;
  assign acc         = in_ch.valid && in_ch.ready;

  // Decode the incoming byte against the line position
  assign await_type = awaiting_r || in_ch.image_start;
  assign first_line = first_r || in_ch.image_start;
  assign cur_pos    = in_ch.image_start ? '0 : pos_r;
  assign bad        = await_type && (in_ch.data_byte > psu_pkg::FLT_LAST_CODE);
  assign pos_inc    = CW'(cur_pos) + CW'(1);
  assign last       = pos_inc >= len_eff;
  assign a_ok       = CW'(cur_pos) >= CW'(bpp_eff);
  assign bpp_idx    = SW'(bpp_eff - BW'(1));
  assign emit       = acc && !halted_r && (bad || !await_type);

  assign rd_en   = acc && !halted_r && !await_type;
  assign rd_addr = cur_pos;

  // Next line state
  always_comb begin
    awaiting_nxt = awaiting_r;
    first_nxt    = first_r;
    halted_nxt   = halted_r;
    pos_nxt      = pos_r;
    filter_nxt   = filter_r;
    for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
      cnt_nxt[k] = cnt_r[k];
    end
    if (acc && !halted_r) begin
      if (await_type) begin
        if (bad) begin
          halted_nxt = 1'b1;
        end else begin
          filter_nxt   = psu_pkg::filter_t'(in_ch.data_byte[2:0]);
          awaiting_nxt = 1'b0;
          first_nxt    = first_line;
          pos_nxt      = '0;
          for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
            cnt_nxt[k] = '0;
          end
        end
      end else if (last) begin
        awaiting_nxt = 1'b1;
        first_nxt    = 1'b0;
        pos_nxt      = '0;
      end else begin
        pos_nxt = PW'(pos_inc);
        // one position counter per pixel size, each wrapping at its own modulus
        for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
          cnt_nxt[k] = (cnt_r[k] == SW'(k)) ? '0 : cnt_r[k] + SW'(1);
        end
      end
    end
  end

  // Line state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b1;
      first_r    <= 1'b1;
      halted_r   <= 1'b0;
      pos_r      <= '0;
      filter_r   <= psu_pkg::FLT_NONE;
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        cnt_r[k] <= '0;
      end
      bpp_r      <= psu_pkg::BPP_RESET;
      len_r      <= psu_pkg::LINE_RESET;
      stg_v_r    <= 1'b0;
    end else begin
      awaiting_r <= awaiting_nxt;
      first_r    <= first_nxt;
      halted_r   <= halted_nxt;
      pos_r      <= pos_nxt;
      filter_r   <= filter_nxt;
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        cnt_r[k] <= cnt_nxt[k];
      end
      if (cfg_we) begin
        case (cfg_index)
          psu_pkg::CFG_BPP:  bpp_r <= cfg_data[BW-1:0];
          psu_pkg::CFG_LINE: len_r <= cfg_data[psu_pkg::LINE_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.ready) begin
        stg_v_r <= emit;
      end
    end
  end

  // Stage payload: load on every transfer that yields a result
  always_ff @(posedge clk) begin
    if (in_ch.ready && emit) begin
      stg_r.err    <= bad;
      stg_r.x      <= in_ch.data_byte;
      stg_r.filter <= filter_r;
      stg_r.last   <= last;
      stg_r.a_ok   <= a_ok;
      stg_r.c_ok   <= a_ok && !first_line;
      stg_r.first  <= first_line;
      slot_r       <= cnt_r[bpp_idx];
      spos_r       <= cur_pos;
    end
  end

  // Halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt state cleared without reset");

  a_halt_on_bad: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !halted_r && bad) |=> (halted_r && stg_v_r && stg_r.err))
    else $error("bad filter type did not halt with an error result");

  a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !halted_r && !await_type && last) |=> (awaiting_r && pos_r == '0))
    else $error("line end did not return to type byte");

endmodule

/* rtl/psu_recon.sv */
module psu_recon #(
  parameter int MAX_LINE_BYTES  = 8192,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               stg_v,
  input  psu_pkg::stage_t                    stg,
  input  logic [((MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1)-1:0] slot,
  input  logic [$clog2(MAX_LINE_BYTES)-1:0]  spos,
  input  logic                               rd_en,
  input  logic [$clog2(MAX_LINE_BYTES)-1:0]  rd_addr,
  output logic                               adv,
  psu_out_if.source                          out_ch
);

  localparam int DW = psu_pkg::DATA_W;

  logic [DW-1:0] prior_mem [MAX_LINE_BYTES];
  logic [DW-1:0] above_r;
  logic [DW-1:0] left_r  [MAX_PIXEL_BYTES];
  logic [DW-1:0] upleft_r [MAX_PIXEL_BYTES];

  logic          out_valid_r;
  logic [DW-1:0] pixel_r;
  logic          last_r;
  logic          bad_r;

  logic          take;
  logic [DW-1:0] a, b, c, pred, val;
  logic [DW:0]   ab_sum;

  function automatic logic [7:0] paeth(input logic [7:0] pa_a, input logic [7:0] pa_b,
                                       input logic [7:0] pa_c);
    logic signed [9:0] da, db, dc;
    logic [9:0]        pa, pb, pc;
    begin
      da = $signed({2'b00, pa_b}) - $signed({2'b00, pa_c});
      db = $signed({2'b00, pa_a}) - $signed({2'b00, pa_c});
      dc = $signed({2'b00, pa_a}) + $signed({2'b00, pa_b}) - $signed({1'b0, pa_c, 1'b0});
      pa = da[9] ? 10'(-da) : 10'(da);
      pb = db[9] ? 10'(-db) : 10'(db);
      pc = dc[9] ? 10'(-dc) : 10'(dc);
      if (pa <= pb && pa <= pc) begin
        paeth = pa_a;
      end else if (pb <= pc) begin
        paeth = pa_b;
      end else begin
        paeth = pa_c;
      end
    end
  endfunction

  assign adv  = !out_valid_r || out_ch.ready;
  assign take = adv && stg_v;

  // Gather the neighbours, zero outside the image
  assign a      = stg.a_ok  ? left_r[slot]   : '0;
  assign b      = stg.first ? '0             : above_r;
  assign c      = stg.c_ok  ? upleft_r[slot] : '0;
  assign ab_sum = {1'b0, a} + {1'b0, b};

  // Predict and rebuild the byte
  always_comb begin
    case (stg.filter)
      psu_pkg::FLT_SUB:   pred = a;
      psu_pkg::FLT_UP:    pred = b;
      psu_pkg::FLT_AVG:   pred = ab_sum[DW:1];
      psu_pkg::FLT_PAETH: pred = paeth(a, b, c);
      default:            pred = '0;
    endcase
    val = stg.x + pred;
  end

  // Previous-line store: read ahead at input transfer, rewrite in place
  always_ff @(posedge clk) begin
    if (rd_en) begin
      above_r <= prior_mem[rd_addr];
    end
    if (take && !stg.err) begin
      prior_mem[spos] <= val;
    end
  end

  // Pixel histories and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_r[k]   <= '0;
        upleft_r[k] <= '0;
      end
    end else begin
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (take && !stg.err) begin
        left_r[slot]   <= val;
        upleft_r[slot] <= b;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take) begin
      pixel_r <= stg.err ? '0 : val;
      last_r  <= stg.err ? 1'b0 : stg.last;
      bad_r   <= stg.err;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_byte = pixel_r;
  assign out_ch.line_last  = last_r;
  assign out_ch.bad_filter = bad_r;

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && bad_r) |-> (pixel_r == '0 && !last_r))
    else $error("error result carries pixel data");

endmodule

/* rtl/png_scanline_unfilter.sv */
// PNG scanline unfilter: one decompressed byte in per cycle, one reconstructed byte out, unless stalled.
// Each result passes through the decode register, loaded at its byte's transfer, and then
// the result register, loaded when the output is not stalled.
// Throughput: 1 byte per cycle unless the output stalls, set by the single read and single write per cycle
// of the previous-line store; a type byte gives a result only when it is bad.
// Reset (rst_n low, synchronous) clears control, configuration, histories and valid flags;
// the payload registers and the line store are not cleared, and the store has no clearing pass.
module png_scanline_unfilter #(
  parameter int MAX_LINE_BYTES  = 8192,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  psu_in_if.sink                         in_ch,
  psu_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [psu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int PW = $clog2(MAX_LINE_BYTES);
  localparam int SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  logic            stg_v;
  psu_pkg::stage_t stg;
  logic [SW-1:0]   slot;
  logic [PW-1:0]   spos;
  logic            rd_en;
  logic [PW-1:0]   rd_addr;
  logic            adv;

  // Decode type bytes and track the line position
  psu_ctrl #(
    .MAX_LINE_BYTES  (MAX_LINE_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .adv       (adv),
    .stg_v_r   (stg_v),
    .stg_r     (stg),
    .slot_r    (slot),
    .spos_r    (spos),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  // Rebuild each byte and hold the result
  psu_recon #(
    .MAX_LINE_BYTES  (MAX_LINE_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_recon (
    .clk     (clk),
    .rst_n   (rst_n),
    .stg_v   (stg_v),
    .stg     (stg),
    .slot    (slot),
    .spos    (spos),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .adv     (adv),
    .out_ch  (out_ch)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int LINE_MAX = 8192;
  localparam int PIX_MAX  = 8;
  localparam int CLK_HALF = 4;

  typedef struct packed {
    logic [psu_pkg::DATA_W-1:0] pixel_byte;
    logic                       line_last;
    logic                       bad_filter;
  } px_result_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [7:0]  data;
    logic        img;
    bit          typed;
    px_result_t  want;
    int unsigned bpp;
    int unsigned len;
  } dir_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [psu_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [psu_pkg::CFG_DATA_W-1:0] cfg_data;

  psu_in_if  in_ch();
  psu_out_if out_ch();

  png_scanline_unfilter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Unfilter state mirrored by the testbench
  logic [7:0]                 prev_row [LINE_MAX];
  logic [7:0]                 left_px [PIX_MAX];
  logic [7:0]                 above_left_px [PIX_MAX];
  int unsigned                col;
  psu_pkg::filter_t           row_filter;
  bit                         want_type;
  bit                         first_row;
  bit                         stopped;
  logic [psu_pkg::BPP_W-1:0]  bpp_reg;
  logic [psu_pkg::LINE_W-1:0] len_reg;

  px_result_t  px_due [$];
  int unsigned n_err;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // Stream shape as seen by the stimulus generator
  int unsigned g_pos;
  int unsigned g_len;
  bit          g_need_type;
  bit          g_force_img;

  int unsigned idle_plan  [4] = '{0, 88, 0, 37};
  int unsigned stall_plan [4] = '{0, 0, 88, 37};
  int unsigned shape_bpp  [10] = '{1, 0, 15, 3, 4, 8, 2, 1, 6, 3};
  int unsigned shape_len  [10] = '{1, 0, 16, 12, 8, 24, 6, 5, 18, 7};

  // Directed rows: pass-through and first Sub bytes at reset values, then a
  // mid-line change of shape, every filter, and an image start mid-line
  dir_row_t dir_rows [25] = '{
    '{ROW_ITEM, 8'(psu_pkg::FLT_NONE),  1'b1, 1'b0, '0, 0, 0},
    '{ROW_ITEM, 8'h00,         1'b0, 1'b1, px_result_t'{8'h00, 1'b0, 1'b0}, 0, 0},
    '{ROW_ITEM, 8'hff,         1'b0, 1'b1, px_result_t'{8'hff, 1'b0, 1'b0}, 0, 0},
    '{ROW_ITEM, 8'(psu_pkg::FLT_SUB),   1'b1, 1'b0, '0, 0, 0},
    '{ROW_ITEM, 8'h10,         1'b0, 1'b1, px_result_t'{8'h10, 1'b0, 1'b0}, 0, 0},
    '{ROW_ITEM, 8'hff,         1'b0, 1'b1, px_result_t'{8'h0f, 1'b0, 1'b0}, 0, 0},
    '{ROW_CFG,  8'h00,         1'b0, 1'b0, '0, 2, 4},
    '{ROW_ITEM, 8'h80,         1'b0, 1'b0, '0, 0, 0},
    '{ROW_ITEM, 8'h7f,         1'b0, 1'b0, '0, 0, 0},
    '{ROW_ITEM, 8'(psu_pkg::FLT_UP),    1'b0, 1'b0, '0, 0, 0},
    '{ROW_ITEM, 8'h01,         1'b0, 1'b0, '0, 0, 0},
    '{ROW_ITEM, 8'hfe,         1'b0, 1'b0, '0, 0, 0},
    '{ROW_ITEM, 8'h80,         1'b0, 1'b0, '0, 0, 0},
    '{ROW_ITEM, 8'h00,         1'b0, 1'b0, '0, 0, 0},
    '{ROW_ITEM, 8'(psu_pkg::FLT_AVG),   1'b0, 1'b0, '0, 0, 0},
    '{ROW_ITEM, 8'hff,         1'b0, 1'b0, '0, 0, 0},
    '{ROW_ITEM, 8'h00,         1'b0, 1'b0, '0, 0, 0},
    '{ROW_ITEM, 8'(psu_pkg::FLT_PAETH), 1'b1, 1'b0, '0, 0, 0},
    '{ROW_ITEM, 8'h01,         1'b0, 1'b0, '0, 0, 0},
    '{ROW_ITEM, 8'hfe,         1'b0, 1'b0, '0, 0, 0},
    '{ROW_ITEM, 8'h7f,         1'b0, 1'b0, '0, 0, 0},
    '{ROW_ITEM, 8'h80,         1'b0, 1'b0, '0, 0, 0},
    '{ROW_ITEM, 8'(psu_pkg::FLT_PAETH), 1'b0, 1'b0, '0, 0, 0},
    '{ROW_ITEM, 8'hff,         1'b0, 1'b0, '0, 0, 0},
    '{ROW_ITEM, 8'h40,         1'b0, 1'b0, '0, 0, 0}
  };

  task automatic note_error(input string msg);
    $display("%0t ns: %s", $time, msg);
    n_err++;
  endtask

  // Rebuild one byte; returns 1 when the byte yields a result
  function automatic bit unfilter_byte(input logic [7:0] x, input logic img,
                                       output px_result_t r);
    int unsigned bpp, len, slot, a, b, c, sum, pa, pb, pc;
    r = '0;
    if (stopped) return 1'b0;
    if (img) begin
      want_type = 1'b1;
      first_row = 1'b1;
      col       = 0;
    end
    // take the filter type, or flag a bad one and stop for good
    if (want_type) begin
      if (x > psu_pkg::FLT_LAST_CODE) begin
        stopped      = 1'b1;
        r.bad_filter = 1'b1;
        return 1'b1;
      end
      row_filter = psu_pkg::filter_t'(x[2:0]);
      want_type  = 1'b0;
      col        = 0;
      return 1'b0;
    end
    bpp  = (bpp_reg == 0) ? 1 : (bpp_reg > PIX_MAX) ? PIX_MAX : bpp_reg;
    len  = (len_reg == 0) ? 1 : (len_reg > LINE_MAX) ? LINE_MAX : len_reg;
    slot = col % bpp;
    b = first_row ? 0 : prev_row[col];
    a = (col >= bpp) ? left_px[slot] : 0;
    c = (col >= bpp && !first_row) ? above_left_px[slot] : 0;
    case (row_filter)
      psu_pkg::FLT_SUB: sum = x + a;
      psu_pkg::FLT_UP:  sum = x + b;
      psu_pkg::FLT_AVG: sum = x + ((a + b) >> 1);
      psu_pkg::FLT_PAETH: begin
        pa = (b > c) ? b - c : c - b;
        pb = (a > c) ? a - c : c - a;
        pc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - (a + b);
        if (pa <= pb && pa <= pc) sum = x + a;
        else if (pb <= pc)        sum = x + b;
        else                      sum = x + c;
      end
      default: sum = x;
    endcase
    r.pixel_byte        = sum[7:0];
    prev_row[col]       = sum[7:0];
    left_px[slot]       = sum[7:0];
    above_left_px[slot] = b[7:0];
    col++;
    // close the line at the length now in force
    if (col >= len) begin
      r.line_last = 1'b1;
      col         = 0;
      want_type   = 1'b1;
      first_row   = 1'b0;
    end
    return 1'b1;
  endfunction

  // Offer one byte, hold until the transfer, then log what it should give
  task automatic send_byte(input logic [7:0] d, input logic img,
                           input bit typed = 1'b0, input px_result_t want = '0);
    px_result_t r;
    bit         got;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= d;
    in_ch.image_start <= img;
    do @(posedge clk); while (!in_ch.ready);
    got = unfilter_byte(d, img, r);
    if (typed)    px_due.push_back(want);
    else if (got) px_due.push_back(r);
  endtask

  // Stop sending and let every pending result and the pipeline empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (px_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the pixel-size register, then the line-length register
  task automatic set_shape(input int unsigned bpp, input int unsigned len);
    int unsigned new_len;
    new_len = (len == 0) ? 1 : (len > LINE_MAX) ? LINE_MAX : len;
    // a longer line would read entries of the row above never written
    if (new_len > g_len) g_force_img = 1'b1;
    g_len = new_len;
    cfg_we    <= 1'b1;
    cfg_index <= psu_pkg::CFG_BPP;
    cfg_data  <= psu_pkg::CFG_DATA_W'(bpp);
    @(posedge clk);
    bpp_reg    = psu_pkg::BPP_W'(bpp);
    cfg_index <= psu_pkg::CFG_LINE;
    cfg_data  <= psu_pkg::CFG_DATA_W'(len);
    @(posedge clk);
    len_reg  = psu_pkg::LINE_W'(len);
    cfg_we  <= 1'b0;
  endtask

  function automatic logic [7:0] rand_px();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly whole lines with random content; now and then cut a line short
  // with a new image
  task automatic random_traffic(input int unsigned n);
    logic img;
    repeat (n) begin
      if (g_need_type || g_force_img || $urandom_range(29) == 0) begin
        img = g_force_img || !g_need_type || ($urandom_range(7) == 0);
        send_byte(8'($urandom_range(int'(psu_pkg::FLT_LAST_CODE))), img);
        g_need_type = 1'b0;
        g_force_img = 1'b0;
        g_pos       = 0;
      end else begin
        send_byte(rand_px(), 1'b0);
        g_pos++;
        if (g_pos >= g_len) begin
          g_pos       = 0;
          g_need_type = 1'b1;
        end
      end
    end
  endtask

  // Receiver stalls
  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_px
    px_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (px_due.size() == 0) begin
        note_error($sformatf("unexpected result: pixel_byte %02h line_last %0b bad_filter %0b",
                             out_ch.pixel_byte, out_ch.line_last, out_ch.bad_filter));
      end else begin
        want = px_due.pop_front();
        if (out_ch.pixel_byte !== want.pixel_byte)
          note_error($sformatf("pixel_byte %02h, predicted %02h",
                               out_ch.pixel_byte, want.pixel_byte));
        if (out_ch.line_last !== want.line_last)
          note_error($sformatf("line_last %0b, predicted %0b",
                               out_ch.line_last, want.line_last));
        if (out_ch.bad_filter !== want.bad_filter)
          note_error($sformatf("bad_filter %0b, predicted %0b",
                               out_ch.bad_filter, want.bad_filter));
      end
    end
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned bpp_pick, len_pick, eff_bpp, s;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = psu_pkg::CFG_BPP;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = '0;
    in_ch.image_start = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    n_err             = 0;
    // state after reset
    for (int i = 0; i < PIX_MAX; i++) begin
      left_px[i]       = 8'h00;
      above_left_px[i] = 8'h00;
    end
    col        = 0;
    row_filter = psu_pkg::FLT_NONE;
    want_type  = 1'b1;
    first_row  = 1'b1;
    stopped    = 1'b0;
    bpp_reg    = psu_pkg::BPP_RESET;
    len_reg    = psu_pkg::LINE_RESET;
    g_pos       = 0;
    g_len       = LINE_MAX;
    g_need_type = 1'b1;
    g_force_img = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, no idling
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        set_shape(dir_rows[i].bpp, dir_rows[i].len);
      end else begin
        send_byte(dir_rows[i].data, dir_rows[i].img, dir_rows[i].typed, dir_rows[i].want);
      end
    end
    g_force_img = 1'b1;

    // random part, one idling pattern per phase
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_plan[p];
      recv_stall_pct = stall_plan[p];
      // over-range registers: start of a line held at the longest length
      if (p == 0) begin
        drain();
        set_shape(15, 16383);
        send_byte(8'(psu_pkg::FLT_SUB), 1'b1);
        repeat (12) send_byte(rand_px(), 1'b0);
        g_pos       = 0;
        g_need_type = 1'b1;
        g_force_img = 1'b1;
      end
      for (int k = 0; k < 3; k++) begin
        s = p * 3 + k;
        if (s < 10) begin
          bpp_pick = shape_bpp[s];
          len_pick = shape_len[s];
        end else begin
          bpp_pick = $urandom_range(15);
          eff_bpp  = (bpp_pick == 0) ? 1 : (bpp_pick > PIX_MAX) ? PIX_MAX : bpp_pick;
          len_pick = eff_bpp * $urandom_range(4, 1);
        end
        drain();
        set_shape(bpp_pick, len_pick);
        random_traffic(35);
      end
    end

    // bad filter type: one error result, then nothing until reset
    drain();
    send_byte(8'($urandom_range(255, int'(psu_pkg::FLT_LAST_CODE) + 1)), 1'b1, 1'b1,
              px_result_t'{8'h00, 1'b0, 1'b1});
    repeat (3) send_byte(rand_px(), 1'($urandom_range(1)));
    drain();
    repeat (16) @(posedge clk);

    if (n_err == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
